[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tbcc_pkg.sv]
`timescale 1ns / 1ps

package tbcc_pkg;

    localparam int TIME_W   = 32;
    localparam int LEVEL_W  = 16;
    localparam int STEP_W   = 8;
    localparam int HOLD_W   = 7;
    localparam int WIN_W    = 16;
    localparam int EVENT_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FLOOR      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_RELOAD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_STEP_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_COUNT_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS        = 3'd5;

    // Reset values of the registers
    localparam logic [LEVEL_W-1:0] RST_LEVEL_FLOOR      = 16'd0;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_RELOAD     = 16'd0;
    localparam logic [LEVEL_W-1:0] RST_ACCEPT_THRESHOLD = 16'd4000;
    localparam logic [STEP_W-1:0]  RST_HOLD_STEP_MS     = 8'd5;
    localparam logic [HOLD_W-1:0]  RST_HOLD_COUNT_LIMIT = 7'd65;
    localparam logic [WIN_W-1:0]   RST_WINDOW_MS        = 16'd350;

    // Button status, also the reported event code
    typedef logic [EVENT_W-1:0] status_t;
    localparam status_t ST_NONE   = 2'd0;
    localparam status_t ST_CLICK  = 2'd1;
    localparam status_t ST_DOUBLE = 2'd2;
    localparam status_t ST_LONG   = 2'd3;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_floor;
        logic [LEVEL_W-1:0] level_reload;
        logic [LEVEL_W-1:0] accept_threshold;
        logic [STEP_W-1:0]  hold_step_ms;
        logic [HOLD_W-1:0]  hold_count_limit;
        logic [WIN_W-1:0]   window_ms;
    } cfg_t;

endpackage

[rtl/tbcc_poll_if.sv]
`timescale 1ns / 1ps

interface tbcc_poll_if;
    import tbcc_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_ms;
    logic              red_pin;
    logic              green_pin;
    logic              red_edge;
    logic              green_edge;

    modport source (
        output valid, now_ms, red_pin, green_pin, red_edge, green_edge,
        input  ready
    );
    modport sink (
        input  valid, now_ms, red_pin, green_pin, red_edge, green_edge,
        output ready
    );
endinterface

[rtl/tbcc_result_if.sv]
`timescale 1ns / 1ps

interface tbcc_result_if;
    import tbcc_pkg::*;

    logic          valid;
    logic          ready;
    status_t       red_event;
    status_t       green_event;

    modport source (output valid, red_event, green_event, input ready);
    modport sink (input valid, red_event, green_event, output ready);
endinterface

[rtl/tbcc_button.sv]
`timescale 1ns / 1ps

module tbcc_button (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          commit,
    input  tbcc_pkg::cfg_t                cfg,
    input  logic [tbcc_pkg::TIME_W-1:0]   now_ms,
    input  logic                          own_pin,
    input  logic                          any_low,
    input  logic                          edge_flag,
    input  logic [tbcc_pkg::LEVEL_W-1:0]  level_in,
    output logic [tbcc_pkg::LEVEL_W-1:0]  level_out,
    output tbcc_pkg::status_t             event_code
);
    import tbcc_pkg::*;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
    localparam logic [HOLD_W-1:0]  HOLD_MAX  = '1;

    logic              pending_reg, pending_next;
    logic              window_reg, window_next;
    status_t           status_reg, status_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic [TIME_W-1:0] start_reg, start_next;

    logic                      pend;
    logic [LEVEL_W-1:0]        stepped;
    logic                      accepted;
    logic                      win_a;
    status_t                   status_a;
    logic [TIME_W-1:0]         start_a;
    logic [TIME_W-1:0]         elapsed;
    logic [STEP_W+HOLD_W-1:0]  hold_ms;
    logic [HOLD_W-1:0]         hold_b;
    status_t                   status_b;

    // One debounce step on the shared level: up when any pin is low, down to the floor
    always_comb
    begin
        if (any_low)
            stepped = (level_in == LEVEL_MAX) ? level_in : level_in + 1'b1;
        else
        begin
            stepped = (level_in != '0) ? level_in - 1'b1 : level_in;
            if (stepped <= cfg.level_floor)
                stepped = cfg.level_floor;
        end
    end

    // Accept the press at threshold; only a pending button steps the level
    always_comb
    begin
        pend     = pending_reg | edge_flag;
        accepted = pend && (stepped >= cfg.accept_threshold);
        if (!pend)
            level_out = level_in;
        else if (accepted)
            level_out = cfg.level_reload;
        else
            level_out = stepped;
    end

    // Open the window or mark a double click
    always_comb
    begin
        win_a    = window_reg;
        status_a = status_reg;
        start_a  = start_reg;
        if (accepted)
        begin
            if (!window_reg)
            begin
                win_a    = 1'b1;
                status_a = ST_CLICK;
                start_a  = now_ms;
            end
            else
                status_a = ST_DOUBLE;
        end
    end

    // Count hold steps and promote to long press
    always_comb
    begin
        elapsed  = now_ms - start_a;
        hold_ms  = cfg.hold_step_ms * hold_reg;
        hold_b   = hold_reg;
        status_b = status_a;
        if ((elapsed > TIME_W'(hold_ms)) && (status_a == ST_CLICK))
        begin
            if (!own_pin && (hold_reg != HOLD_MAX))
                hold_b = hold_reg + 1'b1;
            if (hold_b >= cfg.hold_count_limit)
                status_b = ST_LONG;
        end
    end

    // Report when the window runs out and clear the button
    always_comb
    begin
        pending_next = pend && !accepted;
        start_next   = start_a;
        window_next  = win_a;
        status_next  = status_b;
        hold_next    = hold_b;
        event_code   = ST_NONE;
        if ((elapsed > TIME_W'(cfg.window_ms)) && win_a)
        begin
            event_code  = status_b;
            window_next = 1'b0;
            status_next = ST_NONE;
            hold_next   = '0;
        end
    end

    // Commit the button state once per poll
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            window_reg  <= 1'b0;
            status_reg  <= ST_NONE;
            hold_reg    <= '0;
            start_reg   <= '0;
        end
        else if (commit)
        begin
            pending_reg <= pending_next;
            window_reg  <= window_next;
            status_reg  <= status_next;
            hold_reg    <= hold_next;
            start_reg   <= start_next;
        end
    end

endmodule

[rtl/two_button_click_classifier.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Classifies red and green button presses as click, double click or long press from
// periodic polls. One poll word is taken every clock cycle unless the result side
// stalls; the input register loads it at the accepting edge and the result register
// when it commits. The per-poll work is the chained red-then-green debounce step and
// the window and hold compares, which update the button state registers at commit,
// so throughput is one poll per cycle whenever the result side is ready. The user
// must write configuration through the plain write port only while no poll is in
// flight; the block does not check it. Indexes beyond the register list are ignored.
module two_button_click_classifier (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tbcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbcc_pkg::CFG_DATA_W-1:0]   cfg_data,
    tbcc_poll_if.sink                         poll,
    tbcc_result_if.source                     result
);
    import tbcc_pkg::*;

    cfg_t               cfg_reg;
    logic               s1_valid_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               red_pin_reg, green_pin_reg, red_edge_reg, green_edge_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               out_valid_reg;
    status_t            red_event_reg, green_event_reg;

    logic               advance;
    logic               commit;
    logic               any_low;
    logic [LEVEL_W-1:0] level_mid, level_next;
    status_t            red_ev, green_ev;

    // Advance when the result register is free or being drained
    assign advance    = !out_valid_reg || result.ready;
    assign commit     = s1_valid_reg && advance;
    assign poll.ready = !s1_valid_reg || advance;
    assign any_low    = !red_pin_reg || !green_pin_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_floor      <= RST_LEVEL_FLOOR;
            cfg_reg.level_reload     <= RST_LEVEL_RELOAD;
            cfg_reg.accept_threshold <= RST_ACCEPT_THRESHOLD;
            cfg_reg.hold_step_ms     <= RST_HOLD_STEP_MS;
            cfg_reg.hold_count_limit <= RST_HOLD_COUNT_LIMIT;
            cfg_reg.window_ms        <= RST_WINDOW_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LEVEL_FLOOR:      cfg_reg.level_floor      <= cfg_data;
                REG_LEVEL_RELOAD:     cfg_reg.level_reload     <= cfg_data;
                REG_ACCEPT_THRESHOLD: cfg_reg.accept_threshold <= cfg_data;
                REG_HOLD_STEP_MS:     cfg_reg.hold_step_ms     <= cfg_data[STEP_W-1:0];
                REG_HOLD_COUNT_LIMIT: cfg_reg.hold_count_limit <= cfg_data[HOLD_W-1:0];
                REG_WINDOW_MS:        cfg_reg.window_ms        <= cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (poll.ready)
            s1_valid_reg <= poll.valid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            now_reg        <= poll.now_ms;
            red_pin_reg    <= poll.red_pin;
            green_pin_reg  <= poll.green_pin;
            red_edge_reg   <= poll.red_edge;
            green_edge_reg <= poll.green_edge;
        end
    end

    // Red goes first and hands the debounce level on to green
    tbcc_button u_red (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (commit),
        .cfg        (cfg_reg),
        .now_ms     (now_reg),
        .own_pin    (red_pin_reg),
        .any_low    (any_low),
        .edge_flag  (red_edge_reg),
        .level_in   (level_reg),
        .level_out  (level_mid),
        .event_code (red_ev)
    );

    tbcc_button u_green (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (commit),
        .cfg        (cfg_reg),
        .now_ms     (now_reg),
        .own_pin    (green_pin_reg),
        .any_low    (any_low),
        .edge_flag  (green_edge_reg),
        .level_in   (level_mid),
        .level_out  (level_next),
        .event_code (green_ev)
    );

    // Shared debounce level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= '0;
        else if (commit)
            level_reg <= level_next;
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            red_event_reg   <= red_ev;
            green_event_reg <= green_ev;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.red_event   = red_event_reg;
    assign result.green_event = green_event_reg;

    `ASSERT_NEXT(a_poll_loads_stage, poll.valid && poll.ready, s1_valid_reg,
        "accepted poll did not reach the input register")
    `ASSERT_NEXT(a_commit_gives_result, commit, result.valid,
        "committed poll produced no result word")
    `ASSERT_SAME(a_stall_only_when_full, !poll.ready,
        s1_valid_reg && result.valid && !result.ready,
        "poll side stalled while a stage was free")

endmodule

[sim/click_event_checker.sv]
`timescale 1ns / 1ps

module click_event_checker
    import tbcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tbcc_poll_if                  poll,
    tbcc_result_if                result,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int RED   = 0;
    localparam int GREEN = 1;

    typedef struct packed {
        status_t red;
        status_t green;
    } event_pair_t;

    // Register copy and button state of the predictor
    cfg_t               cfg;
    logic [LEVEL_W-1:0] debounce_lvl;
    logic               pending_press [2];
    logic               window_open   [2];
    status_t            press_status  [2];
    logic [HOLD_W-1:0]  hold_count    [2];
    logic [TIME_W-1:0]  press_start   [2];

    event_pair_t        due_events [$];

    // Step the shared debounce level; return 1 when a press is accepted
    function automatic logic debounce_accepts(input logic rp, input logic gp);
        if (!rp || !gp)
        begin
            if (debounce_lvl != {LEVEL_W{1'b1}})
                debounce_lvl = debounce_lvl + 1'b1;
        end
        else
        begin
            if (debounce_lvl != '0)
                debounce_lvl = debounce_lvl - 1'b1;
            if (debounce_lvl <= cfg.level_floor)
                debounce_lvl = cfg.level_floor;
        end
        if (debounce_lvl >= cfg.accept_threshold)
        begin
            debounce_lvl = cfg.level_reload;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance one button by one poll and return the event it reports
    function automatic status_t classify_button(input int b, input logic [TIME_W-1:0] now,
                                                input logic rp, input logic gp);
        logic [TIME_W-1:0] since;
        logic [TIME_W-1:0] hold_due;
        logic [TIME_W-1:0] win_due;
        logic              own;
        status_t           ev;
        own = (b == RED) ? rp : gp;
        ev  = ST_NONE;
        if (pending_press[b])
        begin
            if (debounce_accepts(rp, gp))
            begin
                pending_press[b] = 1'b0;
                if (!window_open[b])
                begin
                    window_open[b]  = 1'b1;
                    press_status[b] = ST_CLICK;
                    press_start[b]  = now;
                end
                else
                    press_status[b] = ST_DOUBLE;
            end
        end
        since    = now - press_start[b];
        hold_due = {24'd0, cfg.hold_step_ms} * {25'd0, hold_count[b]};
        if (since > hold_due && press_status[b] == ST_CLICK)
        begin
            if (!own && hold_count[b] != {HOLD_W{1'b1}})
                hold_count[b] = hold_count[b] + 1'b1;
            if (hold_count[b] >= cfg.hold_count_limit)
                press_status[b] = ST_LONG;
        end
        win_due = {16'd0, cfg.window_ms};
        if (since > win_due && window_open[b])
        begin
            ev              = press_status[b];
            window_open[b]  = 1'b0;
            hold_count[b]   = '0;
            press_status[b] = ST_NONE;
        end
        return ev;
    endfunction

    // Track register writes, predict each poll word, compare each result word
    always @(posedge clk or negedge rst_n)
    begin : track
        event_pair_t want;
        event_pair_t got;
        if (!rst_n)
        begin
            cfg.level_floor      = RST_LEVEL_FLOOR;
            cfg.level_reload     = RST_LEVEL_RELOAD;
            cfg.accept_threshold = RST_ACCEPT_THRESHOLD;
            cfg.hold_step_ms     = RST_HOLD_STEP_MS;
            cfg.hold_count_limit = RST_HOLD_COUNT_LIMIT;
            cfg.window_ms        = RST_WINDOW_MS;
            debounce_lvl = '0;
            for (int b = 0; b < 2; b++)
            begin
                pending_press[b] = 1'b0;
                window_open[b]   = 1'b0;
                press_status[b]  = ST_NONE;
                hold_count[b]    = '0;
                press_start[b]   = '0;
            end
            due_events.delete();
            mismatches = 0;
        end
        else
        begin
            // latch register writes; unknown indexes drop
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LEVEL_FLOOR:      cfg.level_floor      = cfg_data;
                    REG_LEVEL_RELOAD:     cfg.level_reload     = cfg_data;
                    REG_ACCEPT_THRESHOLD: cfg.accept_threshold = cfg_data;
                    REG_HOLD_STEP_MS:     cfg.hold_step_ms     = cfg_data[STEP_W-1:0];
                    REG_HOLD_COUNT_LIMIT: cfg.hold_count_limit = cfg_data[HOLD_W-1:0];
                    REG_WINDOW_MS:        cfg.window_ms        = cfg_data;
                    default: ;
                endcase
            end

            // compare the result word with the oldest prediction
            if (result.valid && result.ready)
            begin
                got.red   = result.red_event;
                got.green = result.green_event;
                if (due_events.size() == 0)
                begin
                    $error("unexpected result word: red_event %0d, green_event %0d",
                           got.red, got.green);
                    mismatches++;
                end
                else
                begin
                    want = due_events.pop_front();
                    if (got.red !== want.red)
                    begin
                        $error("red_event: expected %0d, actual %0d", want.red, got.red);
                        mismatches++;
                    end
                    if (got.green !== want.green)
                    begin
                        $error("green_event: expected %0d, actual %0d", want.green, got.green);
                        mismatches++;
                    end
                end
            end

            // predict the poll word, red before green
            if (poll.valid && poll.ready)
            begin
                if (poll.red_edge)
                    pending_press[RED] = 1'b1;
                if (poll.green_edge)
                    pending_press[GREEN] = 1'b1;
                want.red   = classify_button(RED, poll.now_ms, poll.red_pin, poll.green_pin);
                want.green = classify_button(GREEN, poll.now_ms, poll.red_pin, poll.green_pin);
                due_events.push_back(want);
            end
        end
        outstanding = due_events.size();
    end

endmodule

[sim/two_button_click_classifier_tb.sv]
`timescale 1ns / 1ps

module two_button_click_classifier_tb;
    import tbcc_pkg::*;

    typedef enum logic [1:0] {G_IDLE, G_CLICK, G_DOUBLE, G_LONG} gesture_t;

    // Indexes past the register list
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  take_ready = 1'b1;

    int                    mismatches;
    int                    outstanding;

    // Stimulus state
    logic [TIME_W-1:0]     poll_time;
    int unsigned           polls_sent   = 0;
    bit                    calm         = 1'b0;
    bit                    sender_quiet = 1'b0;
    int unsigned           set_thr;
    int unsigned           set_step;
    int unsigned           set_limit;
    int unsigned           set_window;
    int unsigned           press_dt;
    int                    stall_left   = 0;
    int                    quiet_left   = 0;

    tbcc_poll_if   poll_bus ();
    tbcc_result_if result_bus ();

    assign result_bus.ready = take_ready;

    two_button_click_classifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .poll      (poll_bus),
        .result    (result_bus)
    );

    click_event_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .poll        (poll_bus),
        .result      (result_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    // Stall the result side in random bursts, with quiet stretches
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            take_ready = 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            take_ready = 1'b1;
            if (quiet_left > 0)
                quiet_left = quiet_left - 1;
            else if (!calm)
            begin
                case ($urandom_range(0, 15))
                    0, 1:    stall_left = $urandom_range(1, 18);
                    2:       quiet_left = $urandom_range(30, 150);
                    default: ;
                endcase
            end
        end
    end

    // Offer one poll word, maybe after an idle burst, and hold it until taken
    task automatic send_poll(input logic [TIME_W-1:0] t, input logic rp, input logic gp,
                             input logic re, input logic ge);
        int unsigned gap;
        gap = 0;
        if (!calm && !sender_quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 18);
        @(negedge clk);
        if (gap > 0)
        begin
            poll_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        poll_bus.valid      = 1'b1;
        poll_bus.now_ms     = t;
        poll_bus.red_pin    = rp;
        poll_bus.green_pin  = gp;
        poll_bus.red_edge   = re;
        poll_bus.green_edge = ge;
        do @(posedge clk); while (!poll_bus.ready);
        polls_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Drain all polls in flight, then load every register
    task automatic configure(input int unsigned restart, input int unsigned accept_lvl,
                             input int unsigned thr, input int unsigned step,
                             input int unsigned limit, input int unsigned win);
        @(negedge clk);
        poll_bus.valid = 1'b0;
        wait (outstanding == 0);
        write_reg(REG_LEVEL_FLOOR,      16'(restart));
        write_reg(REG_LEVEL_RELOAD,     16'(accept_lvl));
        write_reg(REG_ACCEPT_THRESHOLD, 16'(thr));
        write_reg(REG_HOLD_STEP_MS,     {8'd0, 8'(step)});
        write_reg(REG_HOLD_COUNT_LIMIT, {9'd0, 7'(limit)});
        write_reg(REG_WINDOW_MS,        16'(win));
        set_thr    = thr & 16'hFFFF;
        set_step   = step & 8'hFF;
        set_limit  = limit & 7'h7F;
        set_window = win & 16'hFFFF;
        press_dt   = (set_step >> 2) + 1;
    endtask

    // Number of polls a button is held down for a gesture
    function automatic int unsigned hold_polls(input gesture_t kind);
        case (kind)
            G_IDLE:  return 0;
            G_LONG:  return set_thr + (set_limit + 1) * (set_step / press_dt + 1) + 2;
            default: return set_thr + $urandom_range(1, 3);
        endcase
    endfunction

    // Fully random polls: arbitrary pins, edges and time jumps
    task automatic scramble_polls();
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 1) == 1)
                poll_time = $urandom();
            else
                poll_time = poll_time + $urandom_range(0, 50);
            send_poll(poll_time, $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1,
                      $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
        end
    endtask

    // Press, optionally press again, then release and let the windows run out
    task automatic play_gesture(input gesture_t red_kind, input gesture_t green_kind);
        int unsigned       red_low;
        int unsigned       green_low;
        int unsigned       span;
        logic [TIME_W-1:0] origin;
        logic [TIME_W-1:0] deadline;
        bit                red_dbl;
        bit                green_dbl;
        red_low   = hold_polls(red_kind);
        green_low = hold_polls(green_kind);
        red_dbl   = (red_kind == G_DOUBLE);
        green_dbl = (green_kind == G_DOUBLE);
        span      = (red_low > green_low) ? red_low : green_low;
        origin    = poll_time;

        // first press
        for (int k = 0; k < span; k++)
        begin
            poll_time = poll_time + press_dt;
            send_poll(poll_time, k >= red_low, k >= green_low,
                      k == 0 && red_low > 0, k == 0 && green_low > 0);
        end

        // second press for double clicks
        if (red_dbl || green_dbl)
        begin
            repeat (2)
            begin
                poll_time = poll_time + press_dt;
                send_poll(poll_time, 1'b1, 1'b1, 1'b0, 1'b0);
            end
            for (int k = 0; k < set_thr + 2; k++)
            begin
                poll_time = poll_time + press_dt;
                send_poll(poll_time, !red_dbl, !green_dbl, k == 0 && red_dbl, k == 0 && green_dbl);
            end
        end

        // release until both windows have reported, with stray noise
        deadline = (poll_time - origin) + set_window + 2;
        while (poll_time - origin <= deadline)
        begin
            poll_time = poll_time + $urandom_range(1, set_window / 3 + 1);
            if ($urandom_range(0, 7) == 0)
                send_poll(poll_time, $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1,
                          $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
            else
                send_poll(poll_time, 1'b1, 1'b1, 1'b0, 1'b0);
        end
    endtask

    // One register setting followed by random gestures
    task automatic run_phase(input int unsigned idx, input int unsigned quota);
        int unsigned thr;
        int unsigned step;
        int unsigned limit;
        int unsigned win;
        int unsigned first;
        thr   = $urandom_range(1, 6);
        step  = $urandom_range(0, 4);
        limit = $urandom_range(1, 8);
        if (idx == 1)
        begin
            step  = 0;
            limit = 127;
        end
        else if (idx == 2)
        begin
            step  = 255;
            limit = $urandom_range(1, 3);
        end
        win = step * (limit + 1) + $urandom_range(5, 40);
        if (idx == 1)
            win = 16'hFFFF;
        else if ($urandom_range(0, 5) == 0)
            win = $urandom_range(0, 3);
        configure($urandom_range(0, thr), $urandom_range(0, thr), thr, step, limit, win);
        first = polls_sent;
        while (polls_sent - first < quota)
        begin
            sender_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                scramble_polls();
            else
                play_gesture(gesture_t'($urandom_range(0, 3)), gesture_t'($urandom_range(0, 3)));
        end
    endtask

    initial
    begin : stimulus
        int unsigned random_base;
        int unsigned phase_idx;
        poll_bus.valid      = 1'b0;
        poll_bus.now_ms     = '0;
        poll_bus.red_pin    = 1'b1;
        poll_bus.green_pin  = 1'b1;
        poll_bus.red_edge   = 1'b0;
        poll_bus.green_edge = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        poll_time           = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // floor and top of the level: every step accepts, times wrap
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 5, 65, 0);
        write_reg(REG_SPARE_6, 16'(($urandom())));
        write_reg(REG_SPARE_7, 16'(($urandom())));
        send_poll(32'hFFFF_FFFE, 1'b1, 1'b1, 1'b1, 1'b1);
        send_poll(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b1);
        send_poll(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0);

        // zero threshold and zero hold limit
        configure(0, 0, 0, 0, 0, 3);
        send_poll(32'd10, 1'b0, 1'b1, 1'b1, 1'b0);
        send_poll(32'd11, 1'b0, 1'b1, 1'b0, 1'b0);
        send_poll(32'd15, 1'b1, 1'b1, 1'b0, 1'b0);
        send_poll(32'd20, 1'b1, 1'b0, 1'b0, 1'b1);
        send_poll(32'd21, 1'b1, 1'b1, 1'b0, 1'b0);
        send_poll(32'd30, 1'b1, 1'b1, 1'b0, 1'b0);

        // widest window and step: a click, then a double click
        configure(0, 1, 1, 255, 127, 16'hFFFF);
        send_poll(32'd100, 1'b1, 1'b0, 1'b0, 1'b1);
        send_poll(32'd65636, 1'b1, 1'b1, 1'b0, 1'b0);
        send_poll(32'd200000, 1'b0, 1'b1, 1'b1, 1'b0);
        send_poll(32'd200001, 1'b1, 1'b1, 1'b1, 1'b0);
        send_poll(32'd200002, 1'b0, 1'b1, 1'b0, 1'b0);
        send_poll(32'd265600, 1'b1, 1'b1, 1'b0, 1'b0);

        // random gestures over several settings, then a calm finish
        poll_time   = $urandom();
        random_base = polls_sent;
        phase_idx   = 0;
        while (polls_sent - random_base < 340)
        begin
            run_phase(phase_idx, 60);
            phase_idx++;
        end
        calm         = 1'b1;
        sender_quiet = 1'b1;
        run_phase(phase_idx, 60);

        @(negedge clk);
        poll_bus.valid = 1'b0;
        wait (outstanding == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
